[sv/hrc_pkg.sv]
// Shared constants, types and character decode functions for the hex record checker.
`default_nettype none
package hrc_pkg;

   localparam int unsigned MAX_LINE_CHARS = 64;
   localparam int unsigned CHARS_W = 7;
   localparam logic [CHARS_W-1:0] CHARS_LIMIT = CHARS_W'(MAX_LINE_CHARS - 1);

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] BYTE_MAX = 8'hFF;
   localparam logic [7:0] TYPE_END = 8'h01;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_END = 3'd1;
   localparam logic [2:0] ST_NOCOLON = 3'd2;
   localparam logic [2:0] ST_BADSUM = 3'd3;
   localparam logic [2:0] ST_MALFORMED = 3'd4;

   typedef struct packed {
      logic        fire;
      logic [2:0]  status;
      logic [7:0]  record_type;
      logic [15:0] load_address;
      logic [7:0]  byte_count;
   } hrc_result_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) || (c == 8'h0C);
   endfunction

   // bit 4 set: a hex digit, bits 3:0 its value
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end
      if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end
      if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage
`default_nettype wire

[sv/hrc_req_if.sv]
// Character input channel of the hex record checker.
`default_nettype none
interface hrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;

   modport source (output valid, output text_char, input ready);
   modport sink (input valid, input text_char, output ready);
endinterface
`default_nettype wire

[sv/hrc_rsp_if.sv]
// Line result channel of the hex record checker.
`default_nettype none
interface hrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  record_type;
   logic [15:0] load_address;
   logic [7:0]  byte_count;

   modport source (output valid, output status, output record_type, output load_address,
                   output byte_count, input ready);
   modport sink (input valid, input status, input record_type, input load_address,
                 input byte_count, output ready);
endinterface
`default_nettype wire

[sv/hex_record_checker_unit.sv]
// Top level of the Intel HEX record checker: input register, parser, result register.
//
// req_chan takes one ASCII character of hex file text per transfer. rsp_chan
// gives one result per carriage return: status, record type, load address and
// byte count of the finished line.
// A character is parsed while it sits in the input register, in the cycle after
// its transfer; a result goes to the result register when its carriage return
// is parsed, and is on rsp_chan from there.
// One character is taken every cycle while req_chan.ready is high; the parser's
// record state is updated once per character, giving one character per clock.
// When rsp_chan stalls with a result pending, characters that produce no
// result keep flowing; a carriage return waits in the input register until the
// result register frees, and req_chan.ready then drops.
// After an end record or any error the block stays finished: characters are
// still taken but dropped, and no further result appears.
// Synchronous reset empties both registers and returns the parser to
// skipping leading whitespace of a fresh line.
`default_nettype none
module hex_record_checker_unit (
   input wire logic clock,
   input wire logic reset,
   hrc_req_if.sink  req_chan,
   hrc_rsp_if.source rsp_chan
);
   import hrc_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_char_ff;
   logic           out_valid_ff;
   hrc_result_type out_ff;
   hrc_result_type result;
   logic           out_free;
   logic           advance;

   hrc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .text_char (in_char_ff),
      .result    (result)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance = in_valid_ff && (!result.fire || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_char_ff <= req_chan.text_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && result.fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && result.fire) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.status = out_ff.status;
   assign rsp_chan.record_type = out_ff.record_type;
   assign rsp_chan.load_address = out_ff.load_address;
   assign rsp_chan.byte_count = out_ff.byte_count;

endmodule
`default_nettype wire

[sv/hrc_parser.sv]
// Line parser: record state, hex decode, running checksum and line result.
`default_nettype none
module hrc_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            text_char,
   output hrc_pkg::hrc_result_type    result
);
   import hrc_pkg::*;

   typedef enum logic [1:0] {PH_SKIP, PH_RECORD, PH_NOCOLON, PH_DONE} phase_type;

   phase_type          phase_ff, phase_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         bytes_ff, bytes_in;
   logic [CHARS_W-1:0] chars_ff, chars_in;
   logic [3:0]         hi_ff, hi_in;
   logic               pend_ff, pend_in;
   logic [7:0]         count_ff, count_in;
   logic [15:0]        addr_ff, addr_in;
   logic [7:0]         type_ff, type_in;
   logic               fault_ff, fault_in;
   logic               seen_ff, seen_in;
   logic               ok_ff, ok_in;

   logic [4:0]         hex;
   logic [7:0]         data_byte;

   assign hex = hex_value(text_char);
   assign data_byte = {hi_ff, hex[3:0]};

   always_comb begin
      phase_in = phase_ff;
      sum_in = sum_ff;
      bytes_in = bytes_ff;
      chars_in = chars_ff;
      hi_in = hi_ff;
      pend_in = pend_ff;
      count_in = count_ff;
      addr_in = addr_ff;
      type_in = type_ff;
      fault_in = fault_ff;
      seen_in = seen_ff;
      ok_in = ok_ff;
      result = '0;
      if (phase_ff == PH_DONE) begin
         result = '0;
      end else if (text_char == CH_CR) begin
         result.fire = 1'b1;
         if (phase_ff != PH_RECORD) begin
            result.status = ST_NOCOLON;
            phase_in = PH_DONE;
         end else begin
            if (fault_ff || pend_ff || !seen_ff) begin
               result.status = ST_MALFORMED;
            end else if (!ok_ff) begin
               result.status = ST_BADSUM;
            end else if (type_ff == TYPE_END) begin
               result.status = ST_END;
            end else begin
               result.status = ST_OK;
            end
            result.record_type = type_ff;
            result.load_address = addr_ff;
            result.byte_count = count_ff;
            phase_in = (result.status == ST_OK) ? PH_SKIP : PH_DONE;
         end
         sum_in = '0;
         bytes_in = '0;
         chars_in = '0;
         hi_in = '0;
         pend_in = 1'b0;
         count_in = '0;
         addr_in = '0;
         type_in = '0;
         fault_in = 1'b0;
         seen_in = 1'b0;
         ok_in = 1'b0;
      end else begin
         if (chars_ff >= CHARS_LIMIT) begin
            fault_in = 1'b1;
         end else begin
            chars_in = chars_ff + 1'b1;
         end
         case (phase_ff)
            PH_SKIP: begin
               if (text_char == CH_COLON) begin
                  phase_in = PH_RECORD;
               end else if (!is_blank(text_char)) begin
                  phase_in = PH_NOCOLON;
               end
            end
            PH_RECORD: begin
               if (!hex[4]) begin
                  fault_in = 1'b1;
               end else if (!pend_ff) begin
                  hi_in = hex[3:0];
                  pend_in = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (seen_ff) begin
                     fault_in = 1'b1;
                  end else begin
                     sum_in = sum_ff + data_byte;
                     case (bytes_ff)
                        8'd0: count_in = data_byte;
                        8'd1: addr_in = {data_byte, 8'h00};
                        8'd2: addr_in = {addr_ff[15:8], data_byte};
                        8'd3: type_in = data_byte;
                        default: ;
                     endcase
                     if ({1'b0, bytes_ff} == ({1'b0, count_in} + 9'd4)) begin
                        seen_in = 1'b1;
                        ok_in = (sum_in == 8'h00);
                     end
                     if (bytes_ff != BYTE_MAX) begin
                        bytes_in = bytes_ff + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         sum_ff <= '0;
         bytes_ff <= '0;
         chars_ff <= '0;
         hi_ff <= '0;
         pend_ff <= 1'b0;
         count_ff <= '0;
         addr_ff <= '0;
         type_ff <= '0;
         fault_ff <= 1'b0;
         seen_ff <= 1'b0;
         ok_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         sum_ff <= sum_in;
         bytes_ff <= bytes_in;
         chars_ff <= chars_in;
         hi_ff <= hi_in;
         pend_ff <= pend_in;
         count_ff <= count_in;
         addr_ff <= addr_in;
         type_ff <= type_in;
         fault_ff <= fault_in;
         seen_ff <= seen_in;
         ok_ff <= ok_in;
      end
   end

endmodule
`default_nettype wire

[sv/hrc_checker.sv]
// Port-level assertions for the hex record checker and their binding.
`default_nettype none
module hrc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  status,
   input wire logic [7:0]  record_type,
   input wire logic [15:0] load_address,
   input wire logic [7:0]  byte_count
);
   import hrc_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or input blocked after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(record_type)
         && $stable(load_address) && $stable(byte_count))
      else $error("stalled result changed");

   a_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && status != ST_OK |=> !rsp_valid)
      else $error("result after end record or error");

   a_end_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_END |-> record_type == TYPE_END)
      else $error("end status without end record type");

   a_nocolon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_NOCOLON |-> record_type == 8'h00 && load_address == 16'h0000
         && byte_count == 8'h00)
      else $error("missing colon result carries fields");

endmodule

bind hex_record_checker_unit hrc_checker u_hrc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .status       (rsp_chan.status),
   .record_type  (rsp_chan.record_type),
   .load_address (rsp_chan.load_address),
   .byte_count   (rsp_chan.byte_count)
);
`default_nettype wire

[verif/hex_record_checker_unit_tb.sv]
// Self-checking testbench for hex_record_checker_unit: random HEX text in, line verdicts checked.
`default_nettype none
module hex_record_checker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hrc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_CHARS = 600;
   localparam int RANDOM_LINES = 46;
   localparam int NOISE_CHARS = 48;
   localparam int LINE_BUDGET = int'(MAX_LINE_CHARS) - 1;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  record_type;
      logic [15:0] load_address;
      logic [7:0]  byte_count;
   } line_verdict_type;

   typedef enum logic [1:0] {
      SCAN_BLANKS, IN_RECORD, NO_COLON_LINE, STREAM_DONE
   } scan_phase_type;

   typedef enum int {
      END_RECORD, EMPTY_LINE, NO_COLON, BAD_SUM, BAD_DIGIT,
      ODD_DIGITS, SHORT_RECORD, LONG_RECORD, LINE_TOO_LONG, MALFORMED_END
   } stream_end_type;

   typedef enum int {FILL_RANDOM, FILL_ALT, FILL_DIGITS} data_fill_type;

   logic clock;
   logic reset;

   hrc_req_if req_chan();
   hrc_rsp_if rsp_chan();

   hex_record_checker_unit dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   scan_phase_type scan_phase;
   logic [7:0]  sum_acc;
   logic [7:0]  bytes_seen;
   logic [6:0]  line_chars;
   logic [3:0]  upper_nibble;
   logic        half_pending;
   logic [7:0]  count_f;
   logic [15:0] addr_f;
   logic [7:0]  type_f;
   logic        fault;
   logic        sum_seen;
   logic        sum_ok;

   line_verdict_type line_verdicts[$];
   line_verdict_type oldest_verdict;
   logic [7:0]    pending_chars[$];
   logic [7:0]    line_buf[$];

   int mismatch_count = 0;
   int results_checked = 0;
   int lines_sent = 0;
   int chars_sent = 0;
   int cycle_count = 0;
   stream_end_type end_kind;

   bit         req_fire = 1'b0;
   bit         holding = 1'b0;
   logic [7:0] cur_char = 8'h00;
   int         req_gap = 0;
   int         req_burst = 0;
   bit         rsp_fire = 1'b0;
   int         rsp_stall = 0;
   int         rsp_burst = 0;
   logic       rsp_ready_next;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic blank_char(input logic [7:0] c);
      case (c)
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // {is digit, value}
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
   endfunction

   task clear_line_state();
      sum_acc = 8'h00;
      bytes_seen = 8'h00;
      line_chars = 7'd0;
      upper_nibble = 4'h0;
      half_pending = 1'b0;
      count_f = 8'h00;
      addr_f = 16'h0000;
      type_f = 8'h00;
      fault = 1'b0;
      sum_seen = 1'b0;
      sum_ok = 1'b0;
   endtask

   task take_record_byte(input logic [7:0] b);
      if (sum_seen) begin
         fault = 1'b1;
      end else begin
         sum_acc = sum_acc + b;
         case (bytes_seen)
            8'd0: count_f = b;
            8'd1: addr_f = {b, 8'h00};
            8'd2: addr_f[7:0] = b;
            8'd3: type_f = b;
            default: ;
         endcase
         if ({1'b0, bytes_seen} == {1'b0, count_f} + 9'd4) begin
            sum_seen = 1'b1;
            sum_ok = (sum_acc == 8'h00);
         end
         if (bytes_seen != BYTE_MAX) bytes_seen = bytes_seen + 8'd1;
      end
   endtask

   task scan_char(input logic [7:0] c);
      line_verdict_type v;
      logic [4:0] d;
      v = '0;
      if (scan_phase != STREAM_DONE) begin
         if (c == CH_CR) begin
            if (scan_phase != IN_RECORD) begin
               v.status = ST_NOCOLON;
               scan_phase = STREAM_DONE;
            end else begin
               if (fault || half_pending || !sum_seen) v.status = ST_MALFORMED;
               else if (!sum_ok) v.status = ST_BADSUM;
               else if (type_f == TYPE_END) v.status = ST_END;
               else v.status = ST_OK;
               v.record_type = type_f;
               v.load_address = addr_f;
               v.byte_count = count_f;
               if (v.status == ST_OK) scan_phase = SCAN_BLANKS;
               else scan_phase = STREAM_DONE;
            end
            clear_line_state();
            line_verdicts.push_back(v);
         end else begin
            if (line_chars >= CHARS_LIMIT) fault = 1'b1;
            else if (line_chars != 7'd127) line_chars = line_chars + 7'd1;
            case (scan_phase)
               SCAN_BLANKS: begin
                  if (c == CH_COLON) scan_phase = IN_RECORD;
                  else if (!blank_char(c)) scan_phase = NO_COLON_LINE;
               end
               IN_RECORD: begin
                  d = digit_of(c);
                  if (!d[4]) begin
                     fault = 1'b1;
                  end else if (!half_pending) begin
                     upper_nibble = d[3:0];
                     half_pending = 1'b1;
                  end else begin
                     half_pending = 1'b0;
                     take_record_byte({upper_nibble, d[3:0]});
                  end
               end
               default: ;
            endcase
         end
      end
   endtask

   function automatic logic [7:0] digit_char(input logic [3:0] n);
      logic [7:0] base;
      if (n < 4'd10) return 8'h30 + {4'h0, n};
      base = ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41;
      return base + {4'h0, n} - 8'd10;
   endfunction

   function automatic logic [7:0] blank_by_index(input int k);
      case (k)
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0A;
         3: return 8'h0B;
         default: return 8'h0C;
      endcase
   endfunction

   task add_blanks(input int n);
      for (int i = 0; i < n; i++) line_buf.push_back(blank_by_index($urandom_range(0, 4)));
   endtask

   task add_byte(input logic [7:0] b);
      line_buf.push_back(digit_char(b[7:4]));
      line_buf.push_back(digit_char(b[3:0]));
   endtask

   task add_record(input int cnt, input logic [15:0] addr, input logic [7:0] typ,
                   input data_fill_type fill, input logic [7:0] sum_skew);
      logic [7:0] sum;
      logic [7:0] d;
      sum = 8'(cnt) + addr[15:8] + addr[7:0] + typ;
      add_byte(8'(cnt));
      add_byte(addr[15:8]);
      add_byte(addr[7:0]);
      add_byte(typ);
      for (int i = 0; i < cnt; i++) begin
         case (fill)
            FILL_ALT: d = i[0] ? 8'h00 : 8'hFF;
            FILL_DIGITS: d = 8'(i % 8) * 8'h22 + 8'h01;
            default: d = 8'($urandom);
         endcase
         sum = sum + d;
         add_byte(d);
      end
      add_byte(8'h00 - sum + sum_skew);
   endtask

   task send_line();
      foreach (line_buf[i]) pending_chars.push_back(line_buf[i]);
      pending_chars.push_back(CH_CR);
      line_buf.delete();
      lines_sent++;
   endtask

   task add_data_line();
      int cnt;
      int budget;
      logic [7:0] typ;
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 26) : $urandom_range(0, 8);
      budget = LINE_BUDGET - (11 + 2 * cnt);
      add_blanks($urandom_range(0, (budget < 6) ? budget : 6));
      line_buf.push_back(CH_COLON);
      typ = 8'h00;
      if ($urandom_range(0, 3) == 0) begin
         do typ = 8'($urandom); while (typ == TYPE_END);
      end
      add_record(cnt, 16'($urandom), typ, FILL_RANDOM, 8'h00);
      send_line();
   endtask

   task add_closing_line();
      int cnt;
      int start;
      int k;
      logic [7:0] c;
      logic [4:0] d;
      end_kind = stream_end_type'($urandom_range(0, 9));
      cnt = $urandom_range(0, 6);
      if (end_kind == LINE_TOO_LONG)
         add_blanks(LINE_BUDGET - (11 + 2 * cnt) + $urandom_range(1, 90));
      else if (end_kind != NO_COLON)
         add_blanks($urandom_range(0, 5));
      start = line_buf.size();
      case (end_kind)
         EMPTY_LINE: ;
         NO_COLON: begin
            add_blanks($urandom_range(0, 3));
            do c = 8'($urandom); while (blank_char(c) || c == CH_COLON || c == CH_CR);
            line_buf.push_back(c);
            repeat ($urandom_range(0, 20)) begin
               do c = 8'($urandom); while (c == CH_CR);
               line_buf.push_back(c);
            end
         end
         END_RECORD: begin
            line_buf.push_back(CH_COLON);
            add_record(cnt, 16'($urandom), TYPE_END, FILL_RANDOM, 8'h00);
         end
         BAD_SUM: begin
            line_buf.push_back(CH_COLON);
            add_record(cnt, 16'($urandom), 8'($urandom), FILL_RANDOM,
                       8'($urandom_range(1, 255)));
         end
         MALFORMED_END: begin
            line_buf.push_back(CH_COLON);
            add_record(cnt, 16'($urandom), TYPE_END, FILL_RANDOM, 8'($urandom_range(1, 255)));
            add_byte(8'($urandom));
         end
         default: begin
            line_buf.push_back(CH_COLON);
            add_record(cnt, 16'($urandom), 8'($urandom), FILL_RANDOM, 8'h00);
         end
      endcase
      case (end_kind)
         BAD_DIGIT: begin
            k = $urandom_range(start + 1, line_buf.size() - 1);
            do begin
               c = 8'($urandom);
               d = digit_of(c);
            end while (d[4] || c == CH_CR);
            line_buf[k] = c;
         end
         ODD_DIGITS: line_buf.push_back(digit_char(4'($urandom)));
         SHORT_RECORD: repeat ($urandom_range(1, line_buf.size() - start - 1)) line_buf.pop_back();
         LONG_RECORD: add_byte(8'($urandom));
         default: ;
      endcase
      send_line();
   endtask

   task automatic draw_gap(inout int burst, output int gap);
      gap = 0;
      if (burst > 0) begin
         burst--;
      end else if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(8, 40);
      end else begin
         gap = $urandom_range(0, 14);
      end
   endtask

   task check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // transfer on the character channel: advance the predictor
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         scan_char(req_chan.text_char);
         chars_sent++;
         req_fire = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            req_fire = 1'b0;
            holding = 1'b0;
            draw_gap(req_burst, req_gap);
         end
         if (!holding && pending_chars.size() != 0) begin
            if (req_gap == 0) begin
               cur_char = pending_chars.pop_front();
               holding = 1'b1;
            end else begin
               req_gap--;
            end
         end
      end
      req_chan.valid <= holding;
      req_chan.text_char <= cur_char;
   end

   always @(negedge clock) begin
      if (!reset && rsp_fire) begin
         rsp_fire = 1'b0;
         draw_gap(rsp_burst, rsp_stall);
      end
      rsp_ready_next = !reset && rsp_stall == 0;
      if (!reset && rsp_stall > 0 && rsp_chan.valid) rsp_stall--;
      rsp_chan.ready <= rsp_ready_next;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_fire = 1'b1;
         if (line_verdicts.size() == 0) begin
            $display("%0t: extra result, expected none, actual %0d %0h %0h %0h",
                     $time, rsp_chan.status, rsp_chan.record_type, rsp_chan.load_address,
                     rsp_chan.byte_count);
            mismatch_count++;
         end else begin
            oldest_verdict = line_verdicts.pop_front();
            check_field("status", oldest_verdict.status, rsp_chan.status);
            check_field("record_type", oldest_verdict.record_type, rsp_chan.record_type);
            check_field("load_address", oldest_verdict.load_address, rsp_chan.load_address);
            check_field("byte_count", oldest_verdict.byte_count, rsp_chan.byte_count);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d characters queued, %0d results outstanding",
                  $time, pending_chars.size(), line_verdicts.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.text_char = 8'h00;
      rsp_chan.ready = 1'b0;
      scan_phase = SCAN_BLANKS;
      clear_line_state();

      line_buf.push_back(CH_COLON);
      add_record(0, 16'h0000, 8'h00, FILL_RANDOM, 8'h00);
      send_line();
      line_buf.push_back(CH_COLON);
      add_record(26, 16'hFFFF, 8'hFF, FILL_ALT, 8'h00);
      send_line();
      for (int k = 0; k < 5; k++) line_buf.push_back(blank_by_index(k));
      line_buf.push_back(CH_COLON);
      add_record(8, 16'h8000, 8'h02, FILL_DIGITS, 8'h00);
      send_line();
      add_blanks(12);
      line_buf.push_back(CH_COLON);
      add_record(20, 16'h00FF, 8'h04, FILL_RANDOM, 8'h00);
      send_line();
      line_buf.push_back(CH_COLON);
      add_record(1, 16'hFF00, 8'h00, FILL_ALT, 8'h00);
      send_line();
      add_blanks(3);
      line_buf.push_back(CH_COLON);
      add_record(8, 16'h1234, 8'h05, FILL_DIGITS, 8'h00);
      send_line();

      while (pending_chars.size() < RANDOM_CHARS || lines_sent < RANDOM_LINES) add_data_line();
      add_closing_line();
      // the block is finished now: the rest must be dropped
      pending_chars.push_back(8'h00);
      pending_chars.push_back(8'hFF);
      pending_chars.push_back(CH_CR);
      repeat (NOISE_CHARS) pending_chars.push_back(8'($urandom));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || holding) @(posedge clock);
      while (line_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d characters in %0d lines sent, %0d line results checked",
               chars_sent, lines_sent, results_checked);
      $display("stream closed by %s, followed by %0d ignored characters",
               end_kind.name(), NOISE_CHARS + 3);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
